/* design/bpbw_pkg.sv */
// ----------------------------------------------------------------------------
// bpbw_pkg
// Shared types and constants for the binary to packed BCD writer.
// ----------------------------------------------------------------------------
package bpbw_pkg;

	localparam int VALUE_W       = 64;
	localparam int NUM_BYTES_W   = 4;
	localparam int BYTE_W        = 8;
	localparam int DIGIT_W       = 4;
	localparam int RESULT_LIMIT  = 8;
	localparam int MAX_BYTES_DEF = 8;
	localparam int STEP_W        = $clog2(VALUE_W);

	// A BCD digit at or above this value gets the add-three correction.
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

	typedef struct packed {
		logic [VALUE_W-1:0]     value;
		logic [NUM_BYTES_W-1:0] num_bytes;
		logic                   msb_first;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] digits;
		logic              last;
	} res_t;

	typedef struct packed {
		logic start;
	} dab_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dab_stat_t;

endpackage

/* design/bpbw_dabble.sv */
// ----------------------------------------------------------------------------
// bpbw_dabble
// Shift-and-add-three converter: one binary bit enters the BCD register per
// cycle, with all digits corrected in parallel before each shift.
// ----------------------------------------------------------------------------
module bpbw_dabble
	import bpbw_pkg::*;
#(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dab_ctl_t                               ctl,
	input  logic [VALUE_W-1:0]                     value,
	output dab_stat_t                              stat,
	output logic [((MAX_BYTES < RESULT_LIMIT) ? MAX_BYTES : RESULT_LIMIT)-1:0]
	             [BYTE_W-1:0]                      bcd
);

	localparam int NBYTES = (MAX_BYTES < RESULT_LIMIT) ? MAX_BYTES : RESULT_LIMIT;
	localparam int NDIG   = 2 * NBYTES;
	localparam int BCD_W  = NDIG * DIGIT_W;

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;
	logic [BCD_W-1:0]   adj;

	// Digits above the kept ones fall off the top, which leaves the value
	// modulo a power of ten.
	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
				adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
			end else begin
				adj[d*DIGIT_W +: DIGIT_W] = bcd_q[d*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_W - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end else if (ctl.start) begin
			bcd_q <= '0;
			bin_q <= value;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

/* design/binary_to_packed_bcd_writer_top.sv */
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_writer_top
// Converts a 64-bit unsigned value to packed BCD and sends the bytes one per
// transfer in the requested byte order.
// ----------------------------------------------------------------------------
// One input transfer carries a value, a byte count and a byte-order flag. The
// byte count is limited to MAX_BYTES and to eight; a count of zero produces no
// output. The value is converted by a shift-and-add-three unit that takes one
// binary bit per cycle, after which the unit's done flag hands over to the
// output side. The bytes then leave at one per cycle when the output is not
// stalled. Each byte holds the tens digit in the high nibble and the units
// digit in the low nibble; the least significant digit pair comes first in
// little-endian order and last in big-endian order, and the final byte of
// each item is marked with last. Digits that do not fit in the byte count are
// dropped, so the output is the value modulo 100^N for a byte count of N. The
// input is stalled while a conversion or its byte emission is in progress;
// the last byte sits in an output register, so the next item is taken while
// that byte still waits to be transferred.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_writer_top
	import bpbw_pkg::*;
#(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	// Bytes the hardware can produce, and widths of the byte counters.
	localparam int NBYTES = (MAX_BYTES < RESULT_LIMIT) ? MAX_BYTES : RESULT_LIMIT;
	localparam int CNT_W  = $clog2(NBYTES + 1);
	localparam int IDX_W  = (NBYTES > 1) ? $clog2(NBYTES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               count_q;
	logic                           big_q;
	logic [IDX_W-1:0]               idx_q;
	logic                           res_valid_q;
	res_t                           res_q;

	logic                           accept;
	logic [CNT_W-1:0]               count_in;
	logic                           load;
	logic [CNT_W-1:0]               src_full;
	logic [IDX_W-1:0]               src;
	logic                           is_last;
	dab_ctl_t                       dab_ctl;
	dab_stat_t                      dab_stat;
	logic [NBYTES-1:0][BYTE_W-1:0]  bcd;

	// The input side is open only between items.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Byte counts beyond what the hardware keeps saturate.
	always_comb begin
		if (item.num_bytes > NUM_BYTES_W'(NBYTES)) begin
			count_in = CNT_W'(NBYTES);
		end else begin
			count_in = item.num_bytes[CNT_W-1:0];
		end
	end

	// A zero byte count is accepted and dropped without starting the unit.
	assign dab_ctl.start = accept && (count_in != '0);

	bpbw_dabble #(
		.MAX_BYTES (MAX_BYTES)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dab_ctl),
		.value  (item.value),
		.stat   (dab_stat),
		.bcd    (bcd)
	);

	// Digit pair zero is the least significant; big-endian order walks the
	// pairs from the top down.
	always_comb begin
		if (big_q) begin
			src_full = count_q - CNT_W'(1) - CNT_W'(idx_q);
		end else begin
			src_full = CNT_W'(idx_q);
		end
	end
	assign src     = src_full[IDX_W-1:0];
	assign is_last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));

	// During emission, a new byte moves into the output register whenever it is
	// empty or being transferred in this cycle.
	assign load = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (dab_ctl.start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_stat.done) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (load) begin
						idx_q <= idx_q + IDX_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= count_in;
			big_q   <= item.msb_first;
		end
		if (load) begin
			res_q.digits <= bcd[src];
			res_q.last   <= is_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* tb/sv/bpbw_byte_checker.sv */
// ----------------------------------------------------------------------------
// bpbw_byte_checker
// Watches both channels of the packed BCD writer and checks every byte.
// ----------------------------------------------------------------------------
// Each accepted input item is converted to its expected packed BCD bytes on
// the spot; each accepted output byte is compared with the oldest expected
// byte. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module bpbw_byte_checker
	import bpbw_pkg::*;
#(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  logic  item_stall,
	input  item_t item,
	input  logic  res_valid,
	input  logic  res_stall,
	input  res_t  res,
	output int    failures,
	output int    outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RADIX = 10;

	res_t expected_bytes [$];
	int   mismatches = 0;

	// Splits the value into decimal digit pairs, least significant pair first,
	// and queues the bytes in the order the block is meant to send them.
	function automatic void predict_packed_bcd(input item_t it);
		logic [VALUE_W-1:0] rest;
		logic [BYTE_W-1:0]  pairs [RESULT_LIMIT];
		logic [DIGIT_W-1:0] units;
		logic [DIGIT_W-1:0] tens;
		int                 count;
		res_t               byte_exp;
		rest  = it.value;
		count = int'(it.num_bytes);
		if (count > MAX_BYTES)
			count = MAX_BYTES;
		if (count > RESULT_LIMIT)
			count = RESULT_LIMIT;
		for (int i = 0; i < count; i++) begin
			units    = DIGIT_W'(rest % RADIX);
			rest     = rest / RADIX;
			tens     = DIGIT_W'(rest % RADIX);
			rest     = rest / RADIX;
			pairs[i] = {tens, units};
		end
		for (int i = 0; i < count; i++) begin
			byte_exp.digits = it.msb_first ? pairs[count - 1 - i] : pairs[i];
			byte_exp.last   = (i == count - 1);
			expected_bytes.push_back(byte_exp);
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (item_valid && !item_stall)
				predict_packed_bcd(item);
			if (res_valid && !res_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte transfer: digits %h last %b",
						res.digits, res.last);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (res.digits !== want.digits) begin
						$error("digits: expected %h, got %h", want.digits,
							res.digits);
						mismatches++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, res.last);
						mismatches++;
					end
				end
			end
		end
		failures    <= mismatches;
		outstanding <= expected_bytes.size();
	end

endmodule

/* tb/sv/binary_to_packed_bcd_writer_top_test.sv */
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_writer_top_test
// Testbench for the binary to packed BCD writer.
// ----------------------------------------------------------------------------
// A directed set of conversions covers the value extremes, both byte orders,
// a zero byte count, oversized byte counts and values whose upper digits are
// dropped. About 170 random conversions follow. Both channels idle at random,
// apart from one long stretch without gaps. A separate checker predicts and
// compares every output byte; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_writer_top_test
	import bpbw_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BYTES     = MAX_BYTES_DEF;
	localparam int RANDOM_ITEMS  = 170;
	localparam int IDLE_PERCENT  = 9;
	// A conversion takes 64 dabble steps, a hand-over and up to eight bytes
	// of output, so this many cycles is ample for a tail.
	localparam int DRAIN_CYCLES  = 100;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	item_t item;
	logic  res_valid;
	logic  res_stall;
	res_t  res;

	int    failures;
	int    outstanding;
	// While set, neither side inserts idle cycles.
	logic  no_gaps = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	binary_to_packed_bcd_writer_top #(
		.MAX_BYTES (MAX_BYTES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	bpbw_byte_checker #(
		.MAX_BYTES (MAX_BYTES)
	) byte_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// The output side stalls on its own schedule, one decision per clock edge,
	// independent of what the block is doing.
	always @(posedge clk) begin
		res_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// Offers one conversion request and returns once it has been transferred.
	// Valid stays high after the transfer, so back-to-back requests need no
	// second assignment in the same time step; an idle cycle lowers it first.
	task automatic send_conversion(input logic [VALUE_W-1:0] value,
			input int num_bytes, input logic msb_first);
		item_t req;
		req.value     = value;
		req.num_bytes = NUM_BYTES_W'(num_bytes);
		req.msb_first = msb_first;
		while (!no_gaps && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= req;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Random request. Values are often shifted down so that short numbers,
	// which leave the upper digit pairs at zero, show up as often as long
	// ones. Byte counts are mostly legal, sometimes anything the field holds.
	task automatic send_random_conversion();
		logic [VALUE_W-1:0] value;
		int                 num_bytes;
		value = {$urandom, $urandom};
		if ($urandom_range(0, 1))
			value = value >> $urandom_range(1, VALUE_W - 1);
		if ($urandom_range(0, 9) < 8)
			num_bytes = $urandom_range(1, MAX_BYTES);
		else
			num_bytes = $urandom_range(0, (1 << NUM_BYTES_W) - 1);
		send_conversion(value, num_bytes, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Zero and all ones in the value, the top bit alone, both byte orders.
		send_conversion(64'd0, 1, 1'b0);
		send_conversion(64'd0, 8, 1'b1);
		send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b0);
		send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1);
		send_conversion(64'h8000_0000_0000_0000, 8, 1'b1);
		// Sixteen nines fill every nibble; one more digit is dropped entirely.
		send_conversion(64'd9999999999999999, 8, 1'b1);
		send_conversion(64'd10000000000000000, 8, 1'b0);
		// Single byte: largest that fits, and the first value that wraps.
		send_conversion(64'd99, 1, 1'b0);
		send_conversion(64'd100, 1, 1'b1);
		// A zero byte count must produce nothing at all.
		send_conversion(64'd12345678, 0, 1'b1);
		// Counts above the maximum saturate to eight bytes.
		send_conversion(64'd12345678, 9, 1'b0);
		send_conversion(64'd12345678, 15, 1'b1);
		// Counts in between, some with digits above the count dropped.
		send_conversion(64'd1234567890, 3, 1'b1);
		send_conversion(64'd1234567890, 3, 1'b0);
		send_conversion(64'd5, 2, 1'b0);
		send_conversion(64'd987654321, 5, 1'b1);
		send_conversion(64'd4294967296, 7, 1'b0);

		// Hold off until every byte of the directed part has been transferred,
		// so the next request meets a block with nothing in flight.
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);

		// Random part, with one long window where neither side idles.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_gaps <= (i >= 60) && (i < 100);
			send_random_conversion();
		end
		no_gaps    <= 1'b0;
		item_valid <= 1'b0;

		// Drain: wait for every expected byte, then watch a little longer for
		// anything extra the block might still send.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Safety net: a correct run needs well under a tenth of this.
	initial begin
		#3ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
design/bpbw_pkg.sv
design/bpbw_dabble.sv
design/binary_to_packed_bcd_writer_top.sv
tb/sv/bpbw_byte_checker.sv
tb/sv/binary_to_packed_bcd_writer_top_test.sv
